// ===== src/mmfp_pkg.sv =====
// Shared types, constants and helpers for the market message field parser.
// No dependencies; each file but mmfp_if.sv uses it by scoped names.
package mmfp_pkg;

	typedef enum logic [2:0] {
		KIND_A = 3'd0,
		KIND_P = 3'd1,
		KIND_E = 3'd2,
		KIND_X = 3'd3,
		KIND_S = 3'd4,
		KIND_C = 3'd5
	} kind_t;

	localparam logic [7:0] TYPE_A = 8'h41;
	localparam logic [7:0] TYPE_P = 8'h50;
	localparam logic [7:0] TYPE_E = 8'h45;
	localparam logic [7:0] TYPE_X = 8'h58;
	localparam logic [7:0] TYPE_S = 8'h53;
	localparam logic [7:0] TYPE_C = 8'h43;

	// Byte offsets inside a message; the longest layout ends at offset 31.
	localparam int POS_W = 5;

	typedef enum logic [3:0] {
		FLD_START  = 4'd0,
		FLD_TIME   = 4'd1,
		FLD_ORDER  = 4'd2,
		FLD_SIDE   = 4'd3,
		FLD_SHARES = 4'd4,
		FLD_STOCK  = 4'd5,
		FLD_PRICE  = 4'd6,
		FLD_PRINT  = 4'd7,
		FLD_EVENT  = 4'd8
	} field_t;

	// One classified byte, passed from the front to the back through the queue.
	typedef struct packed {
		kind_t       kind;
		field_t      field;
		logic        last;
		logic [7:0]  data;
	} cmd_t;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Offset of the final byte of each layout.
	function automatic logic [POS_W-1:0] last_offset(input kind_t kind);
		logic [POS_W-1:0] off;
		case (kind)
			KIND_A, KIND_P: off = POS_W'(31);
			KIND_E, KIND_C: off = POS_W'(18);
			KIND_X:         off = POS_W'(23);
			default:        off = POS_W'(7);
		endcase
		return off;
	endfunction

endpackage

// ===== src/mmfp_if.sv =====
// Valid/ready channel interfaces for the raw byte stream and decoded records.
// Depends on nothing but logic types; payload names follow the field list.
interface mmfp_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        message_start;

	modport source (output valid, output data_byte, output message_start, input ready);
	modport sink   (input valid, input data_byte, input message_start, output ready);
endinterface

interface mmfp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  message_kind;
	logic [47:0] timestamp_ns;
	logic [63:0] order_reference;
	logic [7:0]  side_code;
	logic [31:0] share_count;
	logic [63:0] stock_name;
	logic [31:0] price_value;
	logic [7:0]  printable_flag;
	logic [7:0]  event_code;

	modport source (output valid, output message_kind, output timestamp_ns,
		output order_reference, output side_code, output share_count,
		output stock_name, output price_value, output printable_flag,
		output event_code, input ready);
	modport sink (input valid, input message_kind, input timestamp_ns,
		input order_reference, input side_code, input share_count,
		input stock_name, input price_value, input printable_flag,
		input event_code, output ready);
endinterface

// ===== src/mmfp_front.sv =====
// Front end: tracks message position and layout, tags each byte with its field.
// Depends on mmfp_pkg and mmfp_in_if; pushes cmd_t beats into the queue.
module mmfp_front (
	input  logic                clk,
	input  logic                arst_n,
	mmfp_in_if.sink             msg,
	output logic                push_valid,
	input  logic                push_ready,
	output mmfp_pkg::cmd_t      push_cmd
);

	logic [mmfp_pkg::POS_W-1:0] pos_q;
	mmfp_pkg::kind_t            kind_q;
	logic                       active_q;

	mmfp_pkg::kind_t            dec_kind;
	logic                       dec_ok;
	logic                       accept;
	logic                       is_last;

	// Map position and layout to the field the byte belongs to.
	function automatic mmfp_pkg::field_t classify(input mmfp_pkg::kind_t kind,
			input logic [mmfp_pkg::POS_W-1:0] pos);
		mmfp_pkg::field_t f;
		if (pos <= mmfp_pkg::POS_W'(6)) begin
			f = mmfp_pkg::FLD_TIME;
		end else if (kind == mmfp_pkg::KIND_S) begin
			f = mmfp_pkg::FLD_EVENT;
		end else if (pos <= mmfp_pkg::POS_W'(14)) begin
			f = mmfp_pkg::FLD_ORDER;
		end else if (kind == mmfp_pkg::KIND_A || kind == mmfp_pkg::KIND_P) begin
			if (pos == mmfp_pkg::POS_W'(15))      f = mmfp_pkg::FLD_SIDE;
			else if (pos <= mmfp_pkg::POS_W'(19)) f = mmfp_pkg::FLD_SHARES;
			else if (pos <= mmfp_pkg::POS_W'(27)) f = mmfp_pkg::FLD_STOCK;
			else                                  f = mmfp_pkg::FLD_PRICE;
		end else begin
			if (pos <= mmfp_pkg::POS_W'(18))      f = mmfp_pkg::FLD_SHARES;
			else if (pos == mmfp_pkg::POS_W'(19)) f = mmfp_pkg::FLD_PRINT;
			else                                  f = mmfp_pkg::FLD_PRICE;
		end
		return f;
	endfunction

	always_comb begin
		dec_ok   = 1'b1;
		dec_kind = mmfp_pkg::KIND_A;
		case (msg.data_byte)
			mmfp_pkg::TYPE_A: dec_kind = mmfp_pkg::KIND_A;
			mmfp_pkg::TYPE_P: dec_kind = mmfp_pkg::KIND_P;
			mmfp_pkg::TYPE_E: dec_kind = mmfp_pkg::KIND_E;
			mmfp_pkg::TYPE_X: dec_kind = mmfp_pkg::KIND_X;
			mmfp_pkg::TYPE_S: dec_kind = mmfp_pkg::KIND_S;
			mmfp_pkg::TYPE_C: dec_kind = mmfp_pkg::KIND_C;
			default:          dec_ok   = 1'b0;
		endcase
	end

	assign is_last = (pos_q == mmfp_pkg::last_offset(kind_q));

	// Hold the stream while the queue is full, even for bytes that make no beat.
	assign msg.ready = push_ready;
	assign accept    = msg.valid && push_ready;

	always_comb begin
		push_cmd.data = msg.data_byte;
		if (msg.message_start) begin
			push_valid     = msg.valid && dec_ok;
			push_cmd.kind  = dec_kind;
			push_cmd.field = mmfp_pkg::FLD_START;
			push_cmd.last  = 1'b0;
		end else begin
			push_valid     = msg.valid && active_q;
			push_cmd.kind  = kind_q;
			push_cmd.field = classify(kind_q, pos_q);
			push_cmd.last  = is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			kind_q   <= mmfp_pkg::KIND_A;
			active_q <= 1'b0;
		end else if (accept) begin
			if (msg.message_start) begin
				// Drop any partial message and start over on the new type byte.
				active_q <= dec_ok;
				kind_q   <= dec_kind;
				pos_q    <= dec_ok ? mmfp_pkg::POS_W'(1) : '0;
			end else if (active_q) begin
				if (is_last) begin
					active_q <= 1'b0;
					pos_q    <= '0;
				end else begin
					pos_q <= pos_q + mmfp_pkg::POS_W'(1);
				end
			end
		end
	end

endmodule

// ===== src/mmfp_queue.sv =====
// Short flip-flop FIFO of classified byte beats between front and back.
// Depends on mmfp_pkg for cmd_t and the depth constants.
module mmfp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  mmfp_pkg::cmd_t      push_cmd,
	output logic                pop_valid,
	input  logic                pop_ready,
	output mmfp_pkg::cmd_t      pop_cmd
);

	mmfp_pkg::cmd_t                 slot_q [mmfp_pkg::QDEPTH];
	logic [mmfp_pkg::QPTR_W-1:0]    head_q;
	logic [mmfp_pkg::QPTR_W-1:0]    tail_q;
	logic [mmfp_pkg::QPTR_W:0]      count_q;
	logic                           do_push;
	logic                           do_pop;

	assign push_ready = (count_q != (mmfp_pkg::QPTR_W+1)'(mmfp_pkg::QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slot_q[head_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[tail_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) tail_q <= tail_q + mmfp_pkg::QPTR_W'(1);
			if (do_pop)  head_q <= head_q + mmfp_pkg::QPTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (mmfp_pkg::QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (mmfp_pkg::QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/mmfp_back.sv =====
// Back end: shifts tagged bytes into field accumulators and registers the record.
// Depends on mmfp_pkg and mmfp_out_if; pops cmd_t beats from the queue.
module mmfp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  mmfp_pkg::cmd_t      pop_cmd,
	mmfp_out_if.source          rec
);

	logic [47:0] time_q,   time_nxt;
	logic [63:0] order_q,  order_nxt;
	logic [7:0]  side_q,   side_nxt;
	logic [31:0] shares_q, shares_nxt;
	logic [63:0] stock_q,  stock_nxt;
	logic [31:0] price_q,  price_nxt;
	logic [7:0]  print_q,  print_nxt;
	logic [7:0]  event_q,  event_nxt;

	logic        out_valid_q;
	logic        do_pop;
	logic        emit;

	// Stall only a final beat while the previous record still waits.
	assign pop_ready = !pop_cmd.last || !out_valid_q || rec.ready;
	assign do_pop    = pop_valid && pop_ready;
	assign emit      = do_pop && pop_cmd.last;

	always_comb begin
		time_nxt   = time_q;
		order_nxt  = order_q;
		side_nxt   = side_q;
		shares_nxt = shares_q;
		stock_nxt  = stock_q;
		price_nxt  = price_q;
		print_nxt  = print_q;
		event_nxt  = event_q;
		case (pop_cmd.field)
			mmfp_pkg::FLD_START: begin
				time_nxt   = '0;
				order_nxt  = '0;
				side_nxt   = '0;
				shares_nxt = '0;
				stock_nxt  = '0;
				price_nxt  = '0;
				print_nxt  = '0;
				event_nxt  = '0;
			end
			mmfp_pkg::FLD_TIME:   time_nxt   = {time_q[39:0], pop_cmd.data};
			mmfp_pkg::FLD_ORDER:  order_nxt  = {order_q[55:0], pop_cmd.data};
			mmfp_pkg::FLD_SIDE:   side_nxt   = pop_cmd.data;
			mmfp_pkg::FLD_SHARES: shares_nxt = {shares_q[23:0], pop_cmd.data};
			mmfp_pkg::FLD_STOCK:  stock_nxt  = {stock_q[55:0], pop_cmd.data};
			mmfp_pkg::FLD_PRICE:  price_nxt  = {price_q[23:0], pop_cmd.data};
			mmfp_pkg::FLD_PRINT:  print_nxt  = pop_cmd.data;
			mmfp_pkg::FLD_EVENT:  event_nxt  = pop_cmd.data;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			time_q   <= time_nxt;
			order_q  <= order_nxt;
			side_q   <= side_nxt;
			shares_q <= shares_nxt;
			stock_q  <= stock_nxt;
			price_q  <= price_nxt;
			print_q  <= print_nxt;
			event_q  <= event_nxt;
		end
		if (emit) begin
			rec.message_kind    <= pop_cmd.kind;
			rec.timestamp_ns    <= time_nxt;
			rec.order_reference <= order_nxt;
			rec.side_code       <= side_nxt;
			rec.share_count     <= shares_nxt;
			rec.stock_name      <= stock_nxt;
			rec.price_value     <= price_nxt;
			rec.printable_flag  <= print_nxt;
			rec.event_code      <= event_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rec.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rec.valid = out_valid_q;

endmodule

// ===== src/market_message_field_parser_core.sv =====
// A record is registered at the output as its last byte's beat leaves the queue.
// Throughput: one byte per cycle unless stalled; at most one record per 8 bytes.
// The byte stream stalls only when the four-entry queue fills behind a record
// that the sink has not taken; the back end sets that by its output register.
// Reset (arst_n low) clears position, queue pointers and record valid at once;
// field accumulators are left unreset and are cleared by every known type byte.
module market_message_field_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	mmfp_in_if.sink     msg,
	mmfp_out_if.source  rec
);

	// Classified beats between the position tracker and the field assembler.
	logic               push_valid;
	logic               push_ready;
	mmfp_pkg::cmd_t     push_cmd;
	logic               pop_valid;
	logic               pop_ready;
	mmfp_pkg::cmd_t     pop_cmd;

	// Front: decode the type byte, advance the byte offset, tag each byte.
	mmfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// Queue: decouple the stream side from a stalled record sink.
	mmfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// Back: shift bytes into fields and hold the finished record for the sink.
	mmfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd),
		.rec        (rec)
	);

endmodule

// ===== src/mmfp_checker.sv =====
// Port-level checks on the record channel of the parser core.
// Depends on mmfp_pkg; bound to market_message_field_parser_core below.
module mmfp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rec_valid,
	input  logic        rec_ready,
	input  logic [2:0]  message_kind,
	input  logic [63:0] order_reference,
	input  logic [31:0] share_count,
	input  logic [63:0] stock_name,
	input  logic [31:0] price_value,
	input  logic [7:0]  printable_flag,
	input  logic [7:0]  event_code,
	input  logic [7:0]  side_code
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_ready |=> rec_valid)
		else $error("record valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_ready |=> $stable(message_kind) && $stable(order_reference)
			&& $stable(stock_name))
		else $error("record changed while stalled");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |-> message_kind <= 3'(mmfp_pkg::KIND_C))
		else $error("record kind out of range");

	a_system_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && message_kind == 3'(mmfp_pkg::KIND_S) |->
			order_reference == '0 && share_count == '0 && stock_name == '0
			&& price_value == '0 && side_code == '0 && printable_flag == '0)
		else $error("system event record carries order fields");

	a_order_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && message_kind != 3'(mmfp_pkg::KIND_S) |-> event_code == '0)
		else $error("order record carries an event code");

endmodule

bind market_message_field_parser_core mmfp_checker u_mmfp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rec_valid       (rec.valid),
	.rec_ready       (rec.ready),
	.message_kind    (rec.message_kind),
	.order_reference (rec.order_reference),
	.share_count     (rec.share_count),
	.stock_name      (rec.stock_name),
	.price_value     (rec.price_value),
	.printable_flag  (rec.printable_flag),
	.event_code      (rec.event_code),
	.side_code       (rec.side_code)
);
